// File: hdl/ght_pkg.sv
// Shared types and constants for the generational handle table.
package ght_pkg;

  localparam int SLOTS    = 1024;
  localparam int TAG_BITS = 48;

  // Fixed field widths of the stream words
  localparam int ACT_W  = 2;
  localparam int ID_W   = 32;
  localparam int GEN_W  = 32;
  localparam int TAG_W  = 48;
  localparam int STS_W  = 3;
  localparam int LIVE_W = 11;

  localparam int IN_BITS   = ACT_W + ID_W + GEN_W + TAG_W + 1;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = STS_W + ID_W + GEN_W + TAG_W + LIVE_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Slot index and counter widths; a counter value of SLOTS means "none"
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int TAG_KEEP = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  localparam logic [CNT_W-1:0] NO_FREE = CNT_W'(SLOTS);
  localparam logic [GEN_W-1:0] GEN_MAX = '1;

  localparam logic [ACT_W-1:0] ACT_REGISTER   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UNREGISTER = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESOLVE    = 2'd2;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 3'd0,
    STS_INVALID   = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_BUSY      = 3'd3,
    STS_STATE     = 3'd4
  } status_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic load;   // latch input word, issue slot read
    logic exec;   // commit action, load result register
  } ght_cmd_t;

  typedef struct packed {
    logic [TAG_KEEP-1:0] tag;
    logic [GEN_W-1:0]    gen;
    logic [CNT_W-1:0]    next;
  } slot_word_t;

endpackage

// File: hdl/ght_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/ght_ctrl.sv
// Controller: accept / execute sequencing and result-valid tracking.
module ght_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output ght_pkg::ght_cmd_t cmd
);
  import ght_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd           = '0;
    unique case (state_r)
      CS_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = CS_EXEC;
        end
      end
      CS_EXEC: begin
        // hold read data until the result register can take the new word
        if (!out_valid_r || out_tready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

// File: hdl/ght_datapath.sv
// Datapath: slot memory, free list head, counters and result register.
module ght_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ght_pkg::ght_cmd_t                   cmd,
  input  logic [ght_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic [ght_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import ght_pkg::*;

  // Unpacked input word
  logic [ACT_W-1:0] in_action;
  logic [ID_W-1:0]  in_id;
  logic [GEN_W-1:0] in_gen;
  logic [TAG_W-1:0] in_tag;
  logic             in_cb;

  assign in_action = in_tdata[ACT_W-1:0];
  assign in_id     = in_tdata[ACT_W +: ID_W];
  assign in_gen    = in_tdata[ACT_W+ID_W +: GEN_W];
  assign in_tag    = in_tdata[ACT_W+ID_W+GEN_W +: TAG_W];
  assign in_cb     = in_tdata[ACT_W+ID_W+GEN_W+TAG_W];

  // Latched action
  logic [ACT_W-1:0]    act_r;
  logic [ID_W-1:0]     id_r;
  logic [GEN_W-1:0]    hgen_r;
  logic [TAG_KEEP-1:0] tag_r;
  logic                cb_r;
  logic [IDX_W-1:0]    addr_r;

  // Table state
  logic [CNT_W-1:0] free_head_r, free_head_nxt;
  logic [CNT_W-1:0] live_r, live_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;   // slots below this were written at least once

  // Result register
  logic [STS_W-1:0]  o_status_r;
  logic [ID_W-1:0]   o_id_r;
  logic [GEN_W-1:0]  o_gen_r;
  logic [TAG_W-1:0]  o_tag_r;
  logic [LIVE_W-1:0] o_live_r;

  logic [ID_W-1:0]  in_id_m1;
  logic [IDX_W-1:0] rd_addr;
  slot_word_t       mem_rd, mem_wd;
  logic             mem_we;

  assign in_id_m1 = in_id - ID_W'(1);
  assign rd_addr  = (in_action == ACT_REGISTER) ? free_head_r[IDX_W-1:0]
                                                : in_id_m1[IDX_W-1:0];

  ght_ram #(
    .WIDTH ($bits(slot_word_t)),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr_r),
    .wdata (mem_wd),
    .re    (cmd.load),
    .raddr (rd_addr),
    .rdata (mem_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      id_r   <= in_id;
      hgen_r <= in_gen;
      tag_r  <= in_tag[TAG_KEEP-1:0];
      cb_r   <= in_cb;
      addr_r <= rd_addr;
    end
  end

  // Slots never written read back with their reset contents
  logic             untouched;
  logic [TAG_KEEP-1:0] rd_tag;
  logic [GEN_W-1:0] rd_gen, gen_inc;
  logic [CNT_W-1:0] rd_next;
  logic [ID_W-1:0]  id_m1;
  logic             in_range, handle_ok;

  assign untouched = (CNT_W'(addr_r) >= fill_r);
  assign rd_tag    = untouched ? '0 : mem_rd.tag;
  assign rd_gen    = untouched ? GEN_W'(1) : mem_rd.gen;
  assign rd_next   = untouched ? (CNT_W'(addr_r) + CNT_W'(1)) : mem_rd.next;
  assign gen_inc   = (rd_gen == GEN_MAX) ? GEN_W'(1) : (rd_gen + GEN_W'(1));
  assign id_m1     = id_r - ID_W'(1);
  assign in_range  = (id_m1 < ID_W'(SLOTS));
  assign handle_ok = (rd_tag != '0) && (rd_gen == hgen_r);

  status_t          sts;
  logic [ID_W-1:0]  r_id;
  logic [GEN_W-1:0] r_gen;
  logic [TAG_W-1:0] r_tag;

  always_comb begin
    sts           = STS_INVALID;
    r_id          = '0;
    r_gen         = '0;
    r_tag         = '0;
    mem_we        = 1'b0;
    mem_wd        = '0;
    free_head_nxt = free_head_r;
    live_nxt      = live_r;
    fill_nxt      = fill_r;
    unique case (act_r)
      ACT_REGISTER: begin
        priority if (tag_r == '0 || !cb_r) begin
          sts = STS_INVALID;
        end else if (id_r != '0 && hgen_r != '0) begin
          sts = STS_STATE;
        end else if (free_head_r >= NO_FREE) begin
          sts = STS_BUSY;
        end else begin
          sts           = STS_OK;
          mem_we        = cmd.exec;
          mem_wd.tag    = tag_r;
          mem_wd.gen    = rd_gen;
          mem_wd.next   = rd_next;
          free_head_nxt = rd_next;
          live_nxt      = live_r + CNT_W'(1);
          if (untouched) begin
            fill_nxt = fill_r + CNT_W'(1);
          end
          r_id  = ID_W'(addr_r) + ID_W'(1);
          r_gen = rd_gen;
        end
      end
      ACT_UNREGISTER, ACT_RESOLVE: begin
        priority if (id_r == '0 || hgen_r == '0) begin
          sts = STS_INVALID;
        end else if (!in_range || !handle_ok) begin
          sts = STS_NOT_FOUND;
        end else if (act_r == ACT_RESOLVE) begin
          sts   = STS_OK;
          r_tag = TAG_W'(rd_tag);
        end else if (live_r == '0) begin
          sts = STS_STATE;
        end else begin
          sts           = STS_OK;
          r_tag         = TAG_W'(rd_tag);
          mem_we        = cmd.exec;
          mem_wd.tag    = '0;
          mem_wd.gen    = gen_inc;
          mem_wd.next   = free_head_r;
          free_head_nxt = CNT_W'(addr_r);
          live_nxt      = live_r - CNT_W'(1);
        end
      end
      default: begin
        sts = STS_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      live_r      <= '0;
      fill_r      <= '0;
    end else if (cmd.exec) begin
      free_head_r <= free_head_nxt;
      live_r      <= live_nxt;
      fill_r      <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      o_status_r <= sts;
      o_id_r     <= r_id;
      o_gen_r    <= r_gen;
      o_tag_r    <= r_tag;
      o_live_r   <= LIVE_W'(live_nxt);
    end
  end

  assign out_tdata = OUT_DATA_W'({o_live_r, o_tag_r, o_gen_r, o_id_r, o_status_r});

endmodule

// File: hdl/generational_handle_table.sv
// Top level of the generational handle table.
//
// A slot map of SLOTS entries with a free list. Each word on the in_ stream
// is one action: register an object tag, unregister a handle, or resolve a
// handle to its tag. Each action yields exactly one word on the out_ stream
// with a status code, the new handle (register), the tag (unregister,
// resolve) and the live slot count after the action.
//
// Sequencing: an accepted word is latched and its slot memory read issued;
// the check, write-back, free list update and result register load follow
// once the result register is free. One action is in flight at a time, so
// the block takes no new word until the last one has been executed.
//
// Reset (rst_n low, synchronous) empties the table at once: all slots read as
// empty with generation 1 and the free list runs in index order. No clearing
// pass is needed; a fill mark tells never-used slots apart.
// When the receiver stalls, the result word holds on out_tdata and the block
// accepts at most one more word, which waits until the result is taken.
module generational_handle_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // action[1:0], handle_id[33:2], handle_generation[65:34],
  // object_tag[113:66], object_has_callbacks[114], zero fill above
  input  logic [ght_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status[2:0], result_id[34:3], result_generation[66:35],
  // result_tag[114:67], live_entries[125:115], zero fill above
  output logic [ght_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import ght_pkg::*;

  ght_cmd_t cmd;

  ght_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ght_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

// File: test/generational_handle_table_tb.sv
// Self-checking testbench for the generational handle table: directed rows, then random traffic.
module generational_handle_table_tb;
  import ght_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int WATCHDOG = 5000;
  localparam logic [TAG_W-1:0] TAG_ALL = '1;

  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     rid;
    logic [GEN_W-1:0]    rgen;
    logic [TAG_W-1:0]    rtag;
    logic [LIVE_W-1:0]   live;
  } table_result_t;

  typedef struct {
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0]  id;
    logic [GEN_W-1:0] gen;
    logic [TAG_W-1:0] tag;
    logic             cb;
    logic             typed;
    table_result_t    res;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // shadow copy of the table
  logic [TAG_W-1:0]  shadow_tag [SLOTS];
  logic [GEN_W-1:0]  shadow_gen [SLOTS];
  logic [CNT_W-1:0]  shadow_next [SLOTS];
  logic [CNT_W-1:0]  free_hd;
  logic [LIVE_W-1:0] live_cnt;
  int unsigned       live_ids [$];

  table_result_t pending_results [$];
  table_result_t exp_w, got_w;
  stim_row_t     dir_rows [$];
  int            errors = 0;
  int            send_pct = 0;
  int            stall_pct = 0;
  int            quiet_cycles = 0;

  generational_handle_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic table_result_t table_step(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                                               logic [GEN_W-1:0] gen, logic [TAG_W-1:0] tag,
                                               logic cb);
    table_result_t r;
    status_t       hs;
    int unsigned   idx;
    r = '0;
    r.status = STS_INVALID;
    idx = 0;
    hs = STS_OK;
    if (id == 0 || gen == 0) hs = STS_INVALID;
    else if (id > SLOTS) hs = STS_NOT_FOUND;
    else begin
      idx = id - 1;
      if (shadow_tag[idx] == 0 || shadow_gen[idx] != gen) hs = STS_NOT_FOUND;
    end
    case (act)
      ACT_REGISTER: begin
        if (tag == 0 || !cb) r.status = STS_INVALID;
        else if (id != 0 && gen != 0) r.status = STS_STATE;
        else if (free_hd >= NO_FREE) r.status = STS_BUSY;
        else begin
          idx = 32'(free_hd);
          free_hd = shadow_next[idx];
          shadow_tag[idx] = tag;
          live_cnt = live_cnt + LIVE_W'(1);
          r.rid = idx + 1;
          r.rgen = shadow_gen[idx];
          r.status = STS_OK;
          live_ids.push_back(idx + 1);
        end
      end
      ACT_UNREGISTER: begin
        r.status = hs;
        if (hs == STS_OK) begin
          if (live_cnt == 0) r.status = STS_STATE;
          else begin
            r.rtag = shadow_tag[idx];
            shadow_tag[idx] = '0;
            shadow_gen[idx] = shadow_gen[idx] + 1;
            if (shadow_gen[idx] == 0) shadow_gen[idx] = 1;  // generation never wraps to zero
            shadow_next[idx] = free_hd;
            free_hd = CNT_W'(idx);
            live_cnt = live_cnt - LIVE_W'(1);
            for (int k = 0; k < live_ids.size(); k++) begin
              if (live_ids[k] == idx + 1) begin
                live_ids.delete(k);
                break;
              end
            end
          end
        end
      end
      ACT_RESOLVE: begin
        r.status = hs;
        if (hs == STS_OK) r.rtag = shadow_tag[idx];
      end
      default: r.status = STS_INVALID;
    endcase
    r.live = live_cnt;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // one word on the input stream; the prediction is taken at acceptance
  task automatic send_action(logic [ACT_W-1:0] act, logic [ID_W-1:0] id, logic [GEN_W-1:0] gen,
                             logic [TAG_W-1:0] tag, logic cb, logic typed,
                             table_result_t typed_res);
    table_result_t r;
    while ($urandom_range(99) < send_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'({cb, tag, gen, id, act});
    do @(posedge clk); while (!in_tready);
    r = table_step(act, id, gen, tag, cb);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic row(logic [ACT_W-1:0] act, logic [ID_W-1:0] id, logic [GEN_W-1:0] gen,
                     logic [TAG_W-1:0] tag, logic cb, logic typed, status_t sts,
                     logic [ID_W-1:0] rid, logic [GEN_W-1:0] rgen, logic [TAG_W-1:0] rtag,
                     logic [LIVE_W-1:0] live);
    stim_row_t s;
    s.act = act; s.id = id; s.gen = gen; s.tag = tag; s.cb = cb; s.typed = typed;
    s.res = '{status: sts, rid: rid, rgen: rgen, rtag: rtag, live: live};
    dir_rows.push_back(s);
  endtask

  task automatic random_action(int reg_pct);
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0]  id;
    logic [GEN_W-1:0] gen;
    logic [TAG_W-1:0] tag;
    logic             cb;
    int unsigned      pick;
    act = ACT_REGISTER;
    id = '0;
    gen = '0;
    tag = TAG_W'({$urandom, $urandom});
    if (tag == 0) tag = 1;
    cb = 1'b1;
    if ($urandom_range(99) < reg_pct) begin
      // clean register; an object with only one half of a handle is still fresh
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) id = $urandom;
        else gen = $urandom;
      end
    end else begin
      pick = $urandom_range(99);
      if (pick < 80 && live_ids.size() != 0) begin
        act = (pick < 40) ? ACT_UNREGISTER : ACT_RESOLVE;
        id = live_ids[$urandom_range(live_ids.size() - 1)];
        gen = shadow_gen[id - 1];
        tag = TAG_W'({$urandom, $urandom});
        cb = 1'($urandom_range(1));
      end else begin
        case ($urandom_range(5))
          0: begin
            act = ACT_W'($urandom_range(3));
            id = $urandom;
            gen = $urandom;
            tag = TAG_W'({$urandom, $urandom});
            cb = 1'($urandom_range(1));
          end
          1: begin  // stale or wrong generation
            act = $urandom_range(1) ? ACT_UNREGISTER : ACT_RESOLVE;
            id = $urandom_range(SLOTS, 1);
            gen = shadow_gen[id - 1] + ($urandom_range(1) ? 32'd1 : -32'd1);
          end
          2: begin
            if ($urandom_range(1)) tag = '0;
            else cb = 1'b0;
          end
          3: begin
            id = $urandom_range(SLOTS * 2, 1);
            gen = $urandom_range(4, 1);
          end
          4: begin  // beyond the table
            act = $urandom_range(1) ? ACT_UNREGISTER : ACT_RESOLVE;
            id = SLOTS + 1 + $urandom_range(3000);
            gen = $urandom_range(3, 1);
          end
          default: begin
            act = ACT_UNUSED;
            id = $urandom_range(SLOTS, 1);
            gen = $urandom_range(3, 1);
          end
        endcase
      end
    end
    send_action(act, id, gen, tag, cb, 1'b0, '0);
  endtask

  // sender holds off until every pending result word is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
      if (out_tvalid && out_tready) begin
        got_w = '{status: status_t'(out_tdata[2:0]), rid: out_tdata[34:3],
                  rgen: out_tdata[66:35], rtag: out_tdata[114:67], live: out_tdata[125:115]};
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result word: expected none, actual %h", $time, out_tdata);
          errors++;
        end else begin
          exp_w = pending_results.pop_front();
          check_field("status", 64'(exp_w.status), 64'(got_w.status));
          check_field("result_id", 64'(exp_w.rid), 64'(got_w.rid));
          check_field("result_generation", 64'(exp_w.rgen), 64'(got_w.rgen));
          check_field("result_tag", 64'(exp_w.rtag), 64'(got_w.rtag));
          check_field("live_entries", 64'(exp_w.live), 64'(got_w.live));
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG) begin
        $display("generational_handle_table regression: fail");
        $finish;
      end else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      shadow_tag[i] = '0;
      shadow_gen[i] = 1;
      shadow_next[i] = CNT_W'(i + 1);
    end
    free_hd = '0;
    live_cnt = '0;

    //  act             id            gen      tag       cb  typed  status         rid rgen rtag live
    row(ACT_RESOLVE,    1,            1,       0,        1, 1, STS_NOT_FOUND, 0, 0, 0,       0);
    row(ACT_UNREGISTER, 0,            1,       5,        1, 1, STS_INVALID,   0, 0, 0,       0);
    row(ACT_RESOLVE,    1,            0,       5,        1, 1, STS_INVALID,   0, 0, 0,       0);
    row(ACT_REGISTER,   0,            0,       0,        1, 1, STS_INVALID,   0, 0, 0,       0);
    row(ACT_REGISTER,   0,            0,       1,        0, 1, STS_INVALID,   0, 0, 0,       0);
    row(ACT_REGISTER,   5,            7,       TAG_ALL,  1, 1, STS_STATE,     0, 0, 0,       0);
    row(ACT_REGISTER,   5,            0,       TAG_ALL,  1, 1, STS_OK,        1, 1, 0,       1);
    row(ACT_REGISTER,   0,            0,       1,        1, 1, STS_OK,        2, 1, 0,       2);
    row(ACT_RESOLVE,    1,            1,       0,        0, 1, STS_OK,        0, 0, TAG_ALL, 2);
    row(ACT_RESOLVE,    '1,           1,       0,        1, 1, STS_NOT_FOUND, 0, 0, 0,       2);
    row(ACT_RESOLVE,    SLOTS + 1,    1,       0,        1, 1, STS_NOT_FOUND, 0, 0, 0,       2);
    row(ACT_RESOLVE,    SLOTS,        1,       0,        1, 1, STS_NOT_FOUND, 0, 0, 0,       2);
    row(ACT_RESOLVE,    1,            2,       0,        1, 1, STS_NOT_FOUND, 0, 0, 0,       2);
    row(ACT_UNREGISTER, 1,            1,       0,        1, 1, STS_OK,        0, 0, TAG_ALL, 1);
    row(ACT_RESOLVE,    1,            1,       0,        1, 1, STS_NOT_FOUND, 0, 0, 0,       1);
    row(ACT_UNREGISTER, 1,            1,       0,        1, 1, STS_NOT_FOUND, 0, 0, 0,       1);
    row(ACT_REGISTER,   0,            GEN_MAX, 'h5a,     1, 1, STS_OK,        1, 2, 0,       2);
    row(ACT_UNUSED,     '1,           GEN_MAX, TAG_ALL,  1, 1, STS_INVALID,   0, 0, 0,       2);
    row(ACT_RESOLVE,    1,            GEN_MAX, 0,        1, 1, STS_NOT_FOUND, 0, 0, 0,       2);
    row(ACT_UNREGISTER, 2,            1,       TAG_ALL,  0, 1, STS_OK,        0, 0, 1,       1);
    row(ACT_RESOLVE,    1,            2,       0,        1, 1, STS_OK,        0, 0, 'h5a,    1);
    row(ACT_REGISTER,   0,            0,       'h123456, 1, 0, STS_OK,        0, 0, 0,       0);
    row(ACT_RESOLVE,    2,            2,       0,        1, 0, STS_OK,        0, 0, 0,       0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // no idling
    foreach (dir_rows[i])
      send_action(dir_rows[i].act, dir_rows[i].id, dir_rows[i].gen, dir_rows[i].tag,
                  dir_rows[i].cb, dir_rows[i].typed, dir_rows[i].res);
    repeat (350) random_action(45);
    drain_results();

    // sender mostly idle; fill the table and push past full
    send_pct = 78;
    while (live_ids.size() < SLOTS) random_action(95);
    repeat (30) random_action(90);
    drain_results();

    // receiver mostly stalled; unregister-heavy
    send_pct = 0;
    stall_pct = 78;
    repeat (300) random_action(20);
    drain_results();

    // both sides idle now and then
    send_pct = 20;
    stall_pct = 20;
    repeat (200) random_action(40);

    drain_results();
    repeat (6) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("generational_handle_table regression: pass");
    else
      $display("generational_handle_table regression: fail");
    $finish;
  end

endmodule
